// ===== rtl/rsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfp_pkg: shared definitions for the ring sampler frame decoder
// Frame layout constants, field widths, register indexes and the chip to
// channel map.
// ----------------------------------------------------------------------------
package rsfp_pkg;

  localparam int HDR_WORDS   = 24;
  localparam int NUM_CHIPS   = 8;
  localparam int PRE_WORDS   = HDR_WORDS + NUM_CHIPS;
  localparam int MAX_DEPTH   = 1024;

  localparam int WORD_W      = 16;
  localparam int PED_W       = 20;
  localparam int VALUE_W     = 21;
  localparam int CH_W        = 4;
  localparam int SLICE_W     = 10;
  localparam int CELL_RES_W  = 10;
  localparam int DEPTH_W     = 11;
  localparam int POS_W       = 15;
  localparam int CHIP_W      = 3;
  localparam int SUM_W       = 17;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  localparam int VAL_MAX     = 1048575;
  localparam int VAL_MIN     = -1048576;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_READ_DEPTH = 1'b0,
    CFG_PED_ENABLE = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  function automatic logic [CH_W-1:0] chip_base(input logic [CHIP_W-1:0] chip);
    logic [CH_W-1:0] base;
    case (chip)
      3'd0: base = 4'd0;
      3'd1: base = 4'd8;
      3'd2: base = 4'd2;
      3'd3: base = 4'd10;
      3'd4: base = 4'd4;
      3'd5: base = 4'd12;
      3'd6: base = 4'd6;
      3'd7: base = 4'd14;
      default: base = 4'd0;
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/rsfp_if.sv =====
// ----------------------------------------------------------------------------
// rsfp_if: word channels of the frame decoder
// Input channel carries frame words and pedestal writes, output channel
// carries decoded samples.
// ----------------------------------------------------------------------------
interface rsfp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [rsfp_pkg::WORD_W-1:0]      frame_word;
  logic [rsfp_pkg::CH_W-1:0]        ped_channel;
  logic [rsfp_pkg::CELL_RES_W-1:0]  ped_cell;
  logic [rsfp_pkg::PED_W-1:0]       ped_value;

  modport source (output valid, func, frame_word, ped_channel, ped_cell, ped_value,
                  input ready);
  modport sink (input valid, func, frame_word, ped_channel, ped_cell, ped_value,
                output ready);
endinterface

interface rsfp_out_if;
  logic                               valid;
  logic                               ready;
  logic [rsfp_pkg::CH_W-1:0]          channel;
  logic [rsfp_pkg::SLICE_W-1:0]       slice;
  logic [rsfp_pkg::CELL_RES_W-1:0]    cell_res;
  logic signed [rsfp_pkg::VALUE_W-1:0] sample_value;
  logic                               last_of_event;

  modport source (output valid, channel, slice, cell_res, sample_value, last_of_event,
                  input ready);
  modport sink (input valid, channel, slice, cell_res, sample_value, last_of_event,
                output ready);
endinterface

// ===== rtl/ring_sampler_frame_pedestal_subtract_core.sv =====
// ----------------------------------------------------------------------------
// ring_sampler_frame_pedestal_subtract_core: frame decoder with pedestal
// subtraction
// Decodes stop cells and sample words of an eight-chip ring sampler frame
// and takes the stored pedestal off each sample.
// ----------------------------------------------------------------------------
// The block takes one word per cycle without gaps while no stalled result
// holds its last stage, and returns each sample through stages sa to sf and
// the output register. Header and stop-cell words give no result; a pedestal
// write takes the single port of the pedestal table on its way through the
// pipeline, in order with the samples around it. The cell index is reduced
// modulo CELLS by a reciprocal multiply and one correction step, spread over
// three stages ahead of the table read. A stalled result waits in the output
// register while the pipeline keeps filling; input is held off only when the
// last stage has a sample that cannot move. The pedestal table has no reset
// and must be loaded before subtraction is enabled.
module ring_sampler_frame_pedestal_subtract_core #(
  parameter int CELLS         = 1024,
  parameter int PED_FRAC_BITS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  rsfp_in_if.sink                            din,
  rsfp_out_if.source                         dout,
  input  logic                               cfg_we,
  input  logic [rsfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rsfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW       = $clog2(CELLS);
  localparam int ADDR_W   = rsfp_pkg::CH_W + CW;
  localparam int X_W      = rsfp_pkg::SUM_W;
  localparam int RECIP_W  = 33 - CW;
  localparam int Q_W      = 18 - CW;
  localparam int PROD_W   = X_W + RECIP_W;
  localparam int DIFF_W   = 26;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / CELLS);

  typedef struct packed {
    logic                              valid;
    rsfp_pkg::op_t                     op;
    logic                              last;
    logic [rsfp_pkg::WORD_W-1:0]       word;
    logic [rsfp_pkg::PED_W-1:0]        ped_value;
    logic [rsfp_pkg::CH_W-1:0]         chan;
    logic [rsfp_pkg::CHIP_W-1:0]       chip;
    logic [rsfp_pkg::DEPTH_W-1:0]      t;
    logic [rsfp_pkg::SLICE_W-1:0]      slice;
    logic [X_W-1:0]                    x;
    logic [Q_W-1:0]                    q;
    logic [X_W-1:0]                    qc;
    logic [CW-1:0]                     cell_idx;
  } stage_t;

  logic [rsfp_pkg::DEPTH_W-1:0] depth;
  logic                         ped_enable;
  logic [rsfp_pkg::POS_W-1:0]   pos;
  logic [rsfp_pkg::WORD_W-1:0]  stop_cells [rsfp_pkg::NUM_CHIPS];

  stage_t sa, sb, sc, sd, se, sf;
  stage_t sa_next, sb_next, sc_next, sd_next, se_next, sf_next;

  logic                          adv;
  logic                          word_accept;
  logic [rsfp_pkg::POS_W-1:0]    total;
  logic [rsfp_pkg::POS_W-1:0]    pos_eff;
  logic [rsfp_pkg::POS_W-1:0]    pos_next;
  logic [rsfp_pkg::POS_W-1:0]    s_index;
  logic                          is_stop;
  logic                          is_sample;
  logic                          is_last;
  logic                          ped_in_range;
  logic                          half;
  logic [PROD_W-1:0]             prod;
  logic [X_W-1:0]                r;
  logic [rsfp_pkg::PED_W-1:0]    ped_rdata;
  logic signed [DIFF_W-1:0]      scaled;
  logic signed [DIFF_W-1:0]      ped_s;
  logic signed [DIFF_W-1:0]      diff;
  logic [rsfp_pkg::VALUE_W-1:0]  value_sat;

  logic                               out_valid;
  logic [rsfp_pkg::CH_W-1:0]          out_channel;
  logic [rsfp_pkg::SLICE_W-1:0]       out_slice;
  logic [rsfp_pkg::CELL_RES_W-1:0]    out_cell;
  logic [rsfp_pkg::VALUE_W-1:0]       out_value;
  logic                               out_last;

  assign adv         = !(sf.valid && out_valid && !dout.ready);
  assign din.ready   = adv;
  assign word_accept = din.valid && adv && !din.func;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= rsfp_pkg::DEPTH_W'(rsfp_pkg::MAX_DEPTH);
      ped_enable <= 1'b0;
    end else if (cfg_we) begin
      case (rsfp_pkg::cfg_index_t'(cfg_index))
        rsfp_pkg::CFG_READ_DEPTH: begin
          if (cfg_data == '0) begin
            depth <= rsfp_pkg::DEPTH_W'(1);
          end else if (cfg_data > rsfp_pkg::DEPTH_W'(rsfp_pkg::MAX_DEPTH)) begin
            depth <= rsfp_pkg::DEPTH_W'(rsfp_pkg::MAX_DEPTH);
          end else begin
            depth <= cfg_data;
          end
        end
        rsfp_pkg::CFG_PED_ENABLE: ped_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    total     = rsfp_pkg::POS_W'(rsfp_pkg::PRE_WORDS) + {depth, 4'b0000};
    pos_eff   = (pos >= total) ? '0 : pos;
    is_stop   = pos_eff inside {[rsfp_pkg::POS_W'(rsfp_pkg::HDR_WORDS) :
                                 rsfp_pkg::POS_W'(rsfp_pkg::PRE_WORDS - 1)]};
    is_sample = pos_eff >= rsfp_pkg::POS_W'(rsfp_pkg::PRE_WORDS);
    is_last   = pos_eff == (total - rsfp_pkg::POS_W'(1));
    pos_next  = is_last ? '0 : pos_eff + rsfp_pkg::POS_W'(1);
    s_index   = pos_eff - rsfp_pkg::POS_W'(rsfp_pkg::PRE_WORDS);
    ped_in_range = {3'b000, din.ped_cell} < 13'(CELLS);

    sa_next           = '0;
    sa_next.valid     = din.valid && (din.func ? ped_in_range : is_sample);
    sa_next.op        = din.func ? rsfp_pkg::OP_WRITE : rsfp_pkg::OP_SAMPLE;
    sa_next.last      = is_last;
    sa_next.word      = din.frame_word;
    sa_next.ped_value = din.ped_value;
    sa_next.chan      = din.ped_channel;
    sa_next.cell_idx  = CW'(din.ped_cell);
    sa_next.chip      = s_index[2:0];
    sa_next.t         = s_index[13:3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      for (int i = 0; i < rsfp_pkg::NUM_CHIPS; i++) begin
        stop_cells[i] <= '0;
      end
    end else if (word_accept) begin
      pos <= pos_next;
      if (is_stop) begin
        stop_cells[pos_eff[2:0]] <= din.frame_word;
      end
    end
  end

  // Slice and channel follow from the slice count across both halves.
  always_comb begin
    half    = sa.t >= depth;
    sb_next = sa;
    if (sa.op == rsfp_pkg::OP_SAMPLE) begin
      sb_next.slice = half ? rsfp_pkg::SLICE_W'(sa.t - depth) : rsfp_pkg::SLICE_W'(sa.t);
      sb_next.chan  = rsfp_pkg::chip_base(sa.chip) + rsfp_pkg::CH_W'(half);
      sb_next.x     = X_W'(stop_cells[sa.chip]) + X_W'(sb_next.slice);
    end
  end

  always_comb begin
    prod      = PROD_W'(sb.x) * PROD_W'(RECIP);
    sc_next   = sb;
    sc_next.q = prod[32 +: Q_W];
  end

  always_comb begin
    sd_next    = sc;
    sd_next.qc = X_W'(32'(sc.q) * 32'(CELLS));
  end

  // The reciprocal quotient is low by at most one, so one subtract finishes it.
  always_comb begin
    r       = sd.x - sd.qc;
    se_next = sd;
    if (sd.op == rsfp_pkg::OP_SAMPLE) begin
      se_next.cell_idx = (r >= X_W'(CELLS)) ? CW'(r - X_W'(CELLS)) : CW'(r);
    end
  end

  always_comb begin
    sf_next       = se;
    sf_next.valid = se.valid && (se.op == rsfp_pkg::OP_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
      sb.valid <= 1'b0;
      sc.valid <= 1'b0;
      sd.valid <= 1'b0;
      se.valid <= 1'b0;
      sf.valid <= 1'b0;
    end else if (adv) begin
      sa <= sa_next;
      sb <= sb_next;
      sc <= sc_next;
      sd <= sd_next;
      se <= se_next;
      sf <= sf_next;
    end
  end

  rsfp_ped_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (rsfp_pkg::PED_W)
  ) u_ped_ram (
    .clk   (clk),
    .en    (adv && se.valid),
    .we    (se.op == rsfp_pkg::OP_WRITE),
    .addr  ({se.chan, se.cell_idx}),
    .wdata (se.ped_value),
    .rdata (ped_rdata)
  );

  always_comb begin
    scaled = $signed(DIFF_W'(sf.word) << PED_FRAC_BITS);
    ped_s  = ped_enable ? $signed(DIFF_W'(ped_rdata)) : '0;
    diff   = scaled - ped_s;
    if (diff > rsfp_pkg::VAL_MAX) begin
      value_sat = rsfp_pkg::VALUE_W'(rsfp_pkg::VAL_MAX);
    end else if (diff < rsfp_pkg::VAL_MIN) begin
      value_sat = rsfp_pkg::VALUE_W'(rsfp_pkg::VAL_MIN);
    end else begin
      value_sat = diff[rsfp_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sf.valid && adv) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sf.valid && adv) begin
      out_channel <= sf.chan;
      out_slice   <= sf.slice;
      out_cell    <= rsfp_pkg::CELL_RES_W'(sf.cell_idx);
      out_value   <= value_sat;
      out_last    <= sf.last;
    end
  end

  assign dout.valid         = out_valid;
  assign dout.channel       = out_channel;
  assign dout.slice         = out_slice;
  assign dout.cell_res      = out_cell;
  assign dout.sample_value  = $signed(out_value);
  assign dout.last_of_event = out_last;

endmodule

// ===== rtl/rsfp_ped_ram.sv =====
// ----------------------------------------------------------------------------
// rsfp_ped_ram: pedestal table storage
// Single-port synchronous RAM with a registered read; the read register
// holds while the port is not enabled or is writing.
// ----------------------------------------------------------------------------
module rsfp_ped_ram #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 20
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/rsfp_checker.sv =====
// ----------------------------------------------------------------------------
// rsfp_checker: port-level checks of the frame decoder
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module rsfp_checker #(
  parameter int CELLS = 1024
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [rsfp_pkg::CH_W-1:0]           channel,
  input logic [rsfp_pkg::SLICE_W-1:0]        slice,
  input logic [rsfp_pkg::CELL_RES_W-1:0]     cell_res,
  input logic signed [rsfp_pkg::VALUE_W-1:0] sample_value,
  input logic                                last_of_event
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(slice) &&
      $stable(cell_res) && $stable(sample_value) && $stable(last_of_event))
    else $error("stalled result word changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CELLS > 1023) || (cell_res < CELLS))
    else $error("cell index beyond the ring");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_event |-> channel == 4'd15)
    else $error("last sample word not on the top channel");

endmodule

bind ring_sampler_frame_pedestal_subtract_core rsfp_checker #(
  .CELLS (CELLS)
) u_rsfp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (dout.valid),
  .out_ready     (dout.ready),
  .channel       (dout.channel),
  .slice         (dout.slice),
  .cell_res      (dout.cell_res),
  .sample_value  (dout.sample_value),
  .last_of_event (dout.last_of_event)
);

// ===== tb/tb_ring_sampler_frame_pedestal_subtract_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_sampler_frame_pedestal_subtract_core: self-checking bench
// Feeds event frames and pedestal loads through the input channel, keeps its
// own copy of the frame position, stop cells and pedestal table, and compares
// every decoded sample field by field against its own decode, under random
// gaps on both channels, a long output stall and many read depth settings.
// ----------------------------------------------------------------------------
module tb_ring_sampler_frame_pedestal_subtract_core;
  import rsfp_pkg::*;

  localparam int CELLS         = 1024;
  localparam int PED_FRAC      = 4;
  localparam int TABLE_SIZE    = (1 << CH_W) * CELLS;
  localparam logic FUNC_FRAME  = 1'b0;
  localparam logic FUNC_PED    = 1'b1;

  localparam int IDLE_SINK_HEAVY   = 0;
  localparam int IDLE_SOURCE_HEAVY = 1;
  localparam int IDLE_NONE         = 2;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int DEEP_WORDS    = 200;
  localparam int MAX_REPORTS   = 40;

  localparam logic [WORD_W-1:0] STOP_SET [NUM_CHIPS] = '{
    16'h0000, 16'h03FF, 16'h0400, 16'hFFFF, 16'h8000, 16'h0005, 16'h0200, 16'h03E8
  };

  typedef struct packed {
    logic                  func;
    logic [WORD_W-1:0]     word;
    logic [CH_W-1:0]       ped_ch;
    logic [CELL_RES_W-1:0] ped_cell;
    logic [PED_W-1:0]      ped_val;
  } feed_item_t;

  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic [SLICE_W-1:0]         slice;
    logic [CELL_RES_W-1:0]      cell_res;
    logic signed [VALUE_W-1:0]  sample_value;
    logic                       last_of_event;
  } sample_t;

  typedef struct packed {
    logic [CH_W-1:0]       channel;
    logic [SLICE_W-1:0]    slice;
    logic [CELL_RES_W-1:0] cell_idx;
    logic                  last;
  } slot_t;

  typedef struct packed {
    logic [POS_W-1:0]                  pos;
    logic [NUM_CHIPS-1:0][WORD_W-1:0]  stop;
    logic [DEPTH_W-1:0]                depth;
  } frame_walk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic drv_valid = 1'b0;
  feed_item_t drv_item = '0;
  logic rdy_q = 1'b0;

  logic hold_arm = 1'b0;
  logic hold_used;
  int hold_left = 0;
  int idle_mode = IDLE_NONE;

  feed_item_t frame_feed_q[$];
  sample_t expected_samples[$];

  frame_walk_t model_walk;
  logic model_sub;
  logic [PED_W-1:0] ped_table [TABLE_SIZE];

  frame_walk_t gen_walk;
  logic gen_sub;
  bit ped_loaded [TABLE_SIZE];

  int n_fed = 0;
  int n_accepted = 0;
  int n_frame_words = 0;
  int n_ped_writes = 0;
  int n_cfg_writes = 0;
  int n_checked = 0;
  int n_frames = 0;
  int n_errors = 0;

  rsfp_in_if in_ch ();
  rsfp_out_if out_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.func        = drv_item.func;
  assign in_ch.frame_word  = drv_item.word;
  assign in_ch.ped_channel = drv_item.ped_ch;
  assign in_ch.ped_cell    = drv_item.ped_cell;
  assign in_ch.ped_value   = drv_item.ped_val;
  assign out_ch.ready      = rdy_q;

  ring_sampler_frame_pedestal_subtract_core #(
    .CELLS         (CELLS),
    .PED_FRAC_BITS (PED_FRAC)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .din       (in_ch),
    .dout      (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances a frame position by one frame word and tells where a sample word lands.
  function automatic bit map_frame_word(inout frame_walk_t w, input logic [WORD_W-1:0] word,
                                        output slot_t s);
    int unsigned depth, total, pos, idx, per_half, rem, chip;
    logic [CH_W-1:0] base;
    s = '0;
    if (w.depth == 0) depth = 1;
    else if (w.depth > MAX_DEPTH) depth = MAX_DEPTH;
    else depth = 32'(w.depth);
    total = PRE_WORDS + 16 * depth;
    if (w.pos >= total) w.pos = '0;
    pos = 32'(w.pos);
    w.pos = POS_W'(pos + 1);
    if (pos < HDR_WORDS) return 1'b0;
    if (pos < PRE_WORDS) begin
      w.stop[pos - HDR_WORDS] = word;
      return 1'b0;
    end
    idx = pos - PRE_WORDS;
    per_half = NUM_CHIPS * depth;
    rem = idx % per_half;
    chip = rem % NUM_CHIPS;
    base = {chip[0], chip[2:1], 1'b0};
    s.channel = base + CH_W'(idx / per_half);
    s.slice = SLICE_W'(rem / NUM_CHIPS);
    s.cell_idx = CELL_RES_W'((w.stop[chip] + rem / NUM_CHIPS) % CELLS);
    s.last = (pos == total - 1);
    if (s.last) w.pos = '0;
    return 1'b1;
  endfunction

  function automatic void decode_word(input feed_item_t it);
    slot_t s;
    sample_t e;
    int v;
    if (it.func == FUNC_PED) begin
      ped_table[{it.ped_ch, it.ped_cell}] = it.ped_val;
    end else if (map_frame_word(model_walk, it.word, s)) begin
      v = int'(it.word) << PED_FRAC;
      if (model_sub) v = v - int'(ped_table[{s.channel, s.cell_idx}]);
      if (v > VAL_MAX) v = VAL_MAX;
      if (v < VAL_MIN) v = VAL_MIN;
      e.channel = s.channel;
      e.slice = s.slice;
      e.cell_res = s.cell_idx;
      e.sample_value = VALUE_W'(v);
      e.last_of_event = s.last;
      expected_samples.push_back(e);
    end
  endfunction

  function automatic bit source_gaps();
    case (idle_mode)
      IDLE_SINK_HEAVY: return $urandom_range(99) < 8;
      IDLE_SOURCE_HEAVY: return $urandom_range(99) < 45;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit sink_takes();
    case (idle_mode)
      IDLE_SINK_HEAVY: return $urandom_range(99) >= 45;
      IDLE_SOURCE_HEAVY: return $urandom_range(99) >= 8;
      default: return 1'b1;
    endcase
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
      drv_item <= '0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        decode_word(drv_item);
        n_accepted++;
      end
      if (!drv_valid || in_ch.ready) begin
        if (frame_feed_q.size() != 0 && !source_gaps()) begin
          drv_item <= frame_feed_q.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    sample_t want;
    if (rst) begin
      rdy_q <= 1'b0;
    end else begin
      if (out_ch.valid && rdy_q) begin
        if (expected_samples.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t: sample word with none expected, ch %0d slice %0d cell %0d value %0d",
                     $time, out_ch.channel, out_ch.slice, out_ch.cell_res, out_ch.sample_value);
          n_errors++;
        end else begin
          want = expected_samples.pop_front();
          check_field("channel", int'(want.channel), int'(out_ch.channel));
          check_field("slice", int'(want.slice), int'(out_ch.slice));
          check_field("cell_res", int'(want.cell_res), int'(out_ch.cell_res));
          check_field("sample_value", int'($signed(want.sample_value)),
                      int'($signed(out_ch.sample_value)));
          check_field("last_of_event", int'(want.last_of_event), int'(out_ch.last_of_event));
          n_checked++;
          if (want.last_of_event) n_frames++;
        end
      end
      rdy_q <= (hold_left == 0) && sink_takes();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic push_ped(input logic [CH_W-1:0] ch, input logic [CELL_RES_W-1:0] cell_idx,
                          input logic [PED_W-1:0] val);
    feed_item_t it;
    it.func = FUNC_PED;
    it.word = WORD_W'($urandom);
    it.ped_ch = ch;
    it.ped_cell = cell_idx;
    it.ped_val = val;
    frame_feed_q.push_back(it);
    ped_loaded[{ch, cell_idx}] = 1'b1;
    n_fed++;
    n_ped_writes++;
  endtask

  // A sample word read with subtraction on gets its pedestal loaded first if it has none.
  task automatic push_word(input logic [WORD_W-1:0] word);
    feed_item_t it;
    slot_t s;
    frame_walk_t w;
    w = gen_walk;
    if (map_frame_word(w, word, s)) begin
      if (gen_sub && !ped_loaded[{s.channel, s.cell_idx}])
        push_ped(s.channel, s.cell_idx, PED_W'($urandom));
    end
    gen_walk = w;
    it.func = FUNC_FRAME;
    it.word = word;
    it.ped_ch = CH_W'($urandom);
    it.ped_cell = CELL_RES_W'($urandom);
    it.ped_val = PED_W'($urandom);
    frame_feed_q.push_back(it);
    n_fed++;
    n_frame_words++;
  endtask

  task automatic push_word_with_ped(input logic [WORD_W-1:0] word, input logic [PED_W-1:0] val);
    slot_t s;
    frame_walk_t w;
    w = gen_walk;
    if (map_frame_word(w, word, s)) push_ped(s.channel, s.cell_idx, val);
    push_word(word);
  endtask

  task automatic settle();
    while (n_accepted != n_fed || expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_READ_DEPTH) begin
      model_walk.depth = data;
      gen_walk.depth = data;
    end else begin
      model_sub = data[0];
      gen_sub = data[0];
    end
    n_cfg_writes++;
  endtask

  initial begin : stimulus
    int r, k, nwords, phase, base_fed;
    logic [CFG_DATA_W-1:0] depth_val;
    model_walk = '0;
    model_walk.depth = DEPTH_W'(MAX_DEPTH);
    model_sub = 1'b0;
    gen_walk = model_walk;
    gen_sub = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    idle_mode = IDLE_NONE;
    write_reg(CFG_READ_DEPTH, CFG_DATA_W'(MAX_DEPTH));
    write_reg(CFG_PED_ENABLE, CFG_DATA_W'(0));
    for (k = 0; k < HDR_WORDS; k++)
      push_word(k == 0 ? 16'h0000 : (k == 1 ? 16'hFFFF : WORD_W'($urandom)));
    for (k = 0; k < NUM_CHIPS; k++) push_word(STOP_SET[k]);
    push_word(16'h0000);
    push_word(16'hFFFF);
    push_word(16'h8000);
    push_word(16'h7FFF);

    // The frame is cut short here: the shallower depth still leaves room to finish it.
    write_reg(CFG_READ_DEPTH, CFG_DATA_W'(1));
    write_reg(CFG_PED_ENABLE, CFG_DATA_W'(1));
    push_word_with_ped(16'h0000, 20'hFFFFF);
    push_word_with_ped(16'hFFFF, 20'h00000);
    push_word_with_ped(16'h0001, 20'h00010);
    push_word_with_ped(16'h1234, 20'h80000);
    for (k = 0; k < 8; k++) push_word(WORD_W'($urandom));

    phase = 0;
    base_fed = n_fed;
    while (n_fed - base_fed < RANDOM_ITEMS) begin
      r = n_fed - base_fed;
      if (r < RANDOM_ITEMS / 3) idle_mode = IDLE_SINK_HEAVY;
      else if (r < 2 * RANDOM_ITEMS / 3) idle_mode = IDLE_SOURCE_HEAVY;
      else idle_mode = IDLE_NONE;
      r = $urandom_range(99);
      if (phase == 1 || r < 8) depth_val = '0;
      else if (r < 22) depth_val = CFG_DATA_W'($urandom_range(7, 12));
      else depth_val = CFG_DATA_W'($urandom_range(1, 6));
      write_reg(CFG_READ_DEPTH, depth_val);
      write_reg(CFG_PED_ENABLE, CFG_DATA_W'($urandom_range(1)));
      nwords = (phase == 3) ? 200 : $urandom_range(30, 160);
      if (phase == 3) hold_arm <= 1'b1;
      for (k = 0; k < nwords; k++) begin
        if ($urandom_range(99) < 6)
          push_ped(CH_W'($urandom), CELL_RES_W'($urandom), PED_W'($urandom));
        r = $urandom_range(15);
        push_word(r == 0 ? 16'h0000 : (r == 1 ? 16'hFFFF : WORD_W'($urandom)));
      end
      phase++;
    end

    // Frame words at the deepest setting, reached through an out-of-range depth.
    idle_mode = IDLE_NONE;
    write_reg(CFG_PED_ENABLE, CFG_DATA_W'(0));
    write_reg(CFG_READ_DEPTH, 11'h7FF);
    for (k = 0; k < DEEP_WORDS; k++) push_word(WORD_W'($urandom));

    settle();
    $display("Fed %0d frame words and %0d pedestal writes under %0d register writes.",
             n_frame_words, n_ped_writes, n_cfg_writes);
    $display("Checked %0d samples in %0d finished frames with %0d errors.",
             n_checked, n_frames, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("%0t: run timed out with %0d samples still expected", $time,
             expected_samples.size());
    $display("status: fail");
    $finish;
  end

endmodule
